// ===== hw/rtl/jpd_pkg.sv =====
// Shared constants, types and control bundles for the joint path densifier.
// Used by every module of the block; depends on nothing else.
package jpd_pkg;

  localparam int NUM_JOINTS = 7;
  localparam int ANGLE_W    = 16;
  localparam int MAX_STEPS  = 64;
  localparam int MS_W       = 15;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int DIFF_W     = ANGLE_W + 1;
  localparam int MAG_W      = ANGLE_W;
  localparam int REM_W      = MS_W + STEP_W;
  localparam int CNT_W      = $clog2(ANGLE_W);

  localparam logic [MS_W-1:0] MAX_STEP_RESET = MS_W'(410);

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [STEP_W-1:0]         step_t;

  typedef struct packed {
    logic load;   // capture a new waypoint
    logic diff;   // form the joint difference
    logic dstep;  // one bit of the per-lane division
    logic prep;   // set up the interpolation increments
    logic adv;    // move to the next interpolated point
  } lane_ctrl_t;

  typedef struct packed {
    logic maxd;   // register the largest difference
    logic clip;   // saturation test and divider setup
    logic qstep;  // one bit of the step-count division
  } merge_ctrl_t;

endpackage

// ===== hw/rtl/jpd_lane.sv =====
// One joint lane: holds the previous and current angle, divides the joint
// difference by the step count and walks the interpolated points. Uses jpd_pkg.
module jpd_lane import jpd_pkg::*; (
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  input  angle_t     b,
  input  step_t      steps,
  output mag_t       mag_out,
  output angle_t     prev_out,
  output angle_t     point_next
);

  angle_t             prev;
  angle_t             base;
  mag_t               mag;
  logic               neg;
  step_t              rem;
  logic [STEP_W:0]    rr;
  logic [STEP_W+1:0]  racc;
  logic [ANGLE_W-1:0] step0;
  logic [ANGLE_W-1:0] step1;
  logic [ANGLE_W-1:0] pt;

  logic signed [DIFF_W-1:0] d;
  logic [DIFF_W-1:0]        dabs;
  logic [STEP_W:0]          dsum;
  logic                     dge;
  logic [STEP_W+1:0]        rsum;
  logic                     rge;
  logic [ANGLE_W-1:0]       magp1;

  assign d     = {prev[ANGLE_W-1], prev} - {base[ANGLE_W-1], base};
  assign dabs  = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  assign dsum  = {rem, mag[MAG_W-1]};
  assign dge   = dsum >= {1'b0, steps};
  assign rsum  = racc + {1'b0, rr};
  // The running remainder is kept below twice the step count, so one
  // correction per point carries the rounding.
  assign rge   = rsum >= {1'b0, steps, 1'b0};
  assign magp1 = ANGLE_W'(mag) + 1'b1;

  assign point_next = angle_t'(pt + (rge ? step1 : step0));
  assign mag_out    = mag;
  assign prev_out   = prev;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      base <= prev;
      prev <= b;
    end
    if (ctrl.diff) begin
      mag <= dabs[MAG_W-1:0];
      neg <= d[DIFF_W-1];
      rem <= '0;
    end
    // Restoring division: the dividend shifts out of mag while the
    // quotient shifts in behind it.
    if (ctrl.dstep) begin
      rem <= dge ? STEP_W'(dsum - {1'b0, steps}) : STEP_W'(dsum);
      mag <= {mag[MAG_W-2:0], dge};
    end
    if (ctrl.prep) begin
      step0 <= neg ? ANGLE_W'(-mag) : ANGLE_W'(mag);
      step1 <= neg ? ANGLE_W'(-magp1) : magp1;
      rr    <= {rem, 1'b0};
      racc  <= {2'b00, steps};
      pt    <= base;
    end
    if (ctrl.adv) begin
      racc <= rge ? rsum - {1'b0, steps, 1'b0} : rsum;
      pt   <= point_next;
    end
  end

endmodule

// ===== hw/rtl/jpd_merge.sv =====
// Merging stage: largest joint difference over all lanes, then the step count
// ceil(maxdiff / max_step) by a bit-serial divider, saturated. Uses jpd_pkg.
module jpd_merge import jpd_pkg::*; (
  input  logic            clk,
  input  merge_ctrl_t     ctrl,
  input  mag_t            mags [NUM_JOINTS],
  input  logic [MS_W-1:0] max_step,
  output step_t           steps,
  output logic            clipped
);

  mag_t             maxdiff;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dsh;
  step_t            q;

  mag_t             tree_max;
  logic [MS_W-1:0]  div;
  logic             qge;

  always_comb begin
    tree_max = mags[0];
    for (int j = 1; j < NUM_JOINTS; j++) begin
      if (mags[j] > tree_max) tree_max = mags[j];
    end
  end

  assign div = (max_step == '0) ? MS_W'(1) : max_step;
  assign qge = rem >= dsh;

  assign steps = clipped ? STEP_W'(MAX_STEPS) :
                 (q == '0) ? STEP_W'(1) : q;

  always_ff @(posedge clk) begin
    if (ctrl.maxd) begin
      maxdiff <= tree_max;
    end
    if (ctrl.clip) begin
      clipped <= REM_W'(maxdiff) > REM_W'(div) * REM_W'(MAX_STEPS);
      rem     <= REM_W'(maxdiff) + REM_W'(div) - REM_W'(1);
      dsh     <= REM_W'(div) << (STEP_W - 1);
      q       <= '0;
    end
    // Without saturation the quotient is below 2**STEP_W, so STEP_W
    // restoring steps give the exact ceiling.
    if (ctrl.qstep) begin
      if (qge) rem <= rem - dsh;
      dsh <= dsh >> 1;
      q   <= STEP_W'({q, qge});
    end
  end

endmodule

// ===== hw/rtl/joint_path_densifier_top.sv =====
// Top level of the joint path densifier: sequencer, lanes, merge stage and
// output register. Depends on jpd_pkg, jpd_lane and jpd_merge.

// Takes seven-joint waypoints and emits linearly interpolated points so that
// no joint moves more than max_step between points unless the step count
// saturates at MAX_STEPS; the first waypoint of a path comes out unchanged as
// one beat. One waypoint is handled at a time. Any other waypoint first goes
// through setup (difference, max over the lanes, saturation test, the
// bit-serial step-count divide, the per-lane bit-serial divide of each
// difference by the step count and the increment setup), then emits one point
// per cycle, steps points in all, when the output side keeps up. The input is
// ready again once the last point of a run is in the output register.
module joint_path_densifier_top import jpd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [MS_W-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  angle_t          joint_0,
  input  angle_t          joint_1,
  input  angle_t          joint_2,
  input  angle_t          joint_3,
  input  angle_t          joint_4,
  input  angle_t          joint_5,
  input  angle_t          joint_6,
  input  logic            end_of_path,
  output logic            out_valid,
  input  logic            out_ready,
  output angle_t          out_joint_0,
  output angle_t          out_joint_1,
  output angle_t          out_joint_2,
  output angle_t          out_joint_3,
  output angle_t          out_joint_4,
  output angle_t          out_joint_5,
  output angle_t          out_joint_6,
  output logic            last_of_run,
  output logic            steps_clipped
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PASS = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_MAX  = 4'd3;
  localparam logic [3:0] S_CLIP = 4'd4;
  localparam logic [3:0] S_QDIV = 4'd5;
  localparam logic [3:0] S_LDIV = 4'd6;
  localparam logic [3:0] S_PREP = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]      state;
  logic [3:0]      state_next;
  logic [CNT_W-1:0] cnt;
  step_t           s_cnt;
  logic            have_prev;
  logic [MS_W-1:0] max_step;

  angle_t          out_pt [NUM_JOINTS];

  angle_t          in_joint   [NUM_JOINTS];
  mag_t            mags       [NUM_JOINTS];
  angle_t          prev_pt    [NUM_JOINTS];
  angle_t          next_pt    [NUM_JOINTS];
  lane_ctrl_t      lane_ctrl;
  merge_ctrl_t     merge_ctrl;
  step_t           steps;
  logic            clipped;
  logic            in_fire;
  logic            out_free;
  logic            run_last;

  assign in_joint[0] = joint_0;
  assign in_joint[1] = joint_1;
  assign in_joint[2] = joint_2;
  assign in_joint[3] = joint_3;
  assign in_joint[4] = joint_4;
  assign in_joint[5] = joint_5;
  assign in_joint[6] = joint_6;

  assign out_joint_0 = out_pt[0];
  assign out_joint_1 = out_pt[1];
  assign out_joint_2 = out_pt[2];
  assign out_joint_3 = out_pt[3];
  assign out_joint_4 = out_pt[4];
  assign out_joint_5 = out_pt[5];
  assign out_joint_6 = out_pt[6];

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign run_last = (s_cnt == steps);

  always_comb begin
    lane_ctrl        = '0;
    merge_ctrl       = '0;
    lane_ctrl.load   = in_fire;
    lane_ctrl.diff   = (state == S_DIFF);
    lane_ctrl.dstep  = (state == S_LDIV);
    lane_ctrl.prep   = (state == S_PREP);
    lane_ctrl.adv    = (state == S_EMIT) && out_free;
    merge_ctrl.maxd  = (state == S_MAX);
    merge_ctrl.clip  = (state == S_CLIP);
    merge_ctrl.qstep = (state == S_QDIV);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) state_next = have_prev ? S_DIFF : S_PASS;
      S_PASS: if (out_free) state_next = S_IDLE;
      S_DIFF: state_next = S_MAX;
      S_MAX:  state_next = S_CLIP;
      S_CLIP: state_next = S_QDIV;
      S_QDIV: if (cnt == CNT_W'(STEP_W - 1)) state_next = S_LDIV;
      S_LDIV: if (cnt == CNT_W'(ANGLE_W - 1)) state_next = S_PREP;
      S_PREP: state_next = S_EMIT;
      S_EMIT: if (out_free && run_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      s_cnt     <= '0;
      have_prev <= 1'b0;
      max_step  <= MAX_STEP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) max_step <= cfg_data;
      if (in_fire) have_prev <= !end_of_path;

      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end

      if (state == S_PREP) begin
        s_cnt <= STEP_W'(1);
      end else if (lane_ctrl.adv) begin
        s_cnt <= s_cnt + 1'b1;
      end

      if (((state == S_PASS) || (state == S_EMIT)) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload; a path-start beat repeats the stored waypoint.
  always_ff @(posedge clk) begin
    if ((state == S_PASS) && out_free) begin
      out_pt        <= prev_pt;
      last_of_run   <= 1'b1;
      steps_clipped <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_pt        <= next_pt;
      last_of_run   <= run_last;
      steps_clipped <= clipped;
    end
  end

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
    jpd_lane u_lane (
      .clk        (clk),
      .ctrl       (lane_ctrl),
      .b          (in_joint[j]),
      .steps      (steps),
      .mag_out    (mags[j]),
      .prev_out   (prev_pt[j]),
      .point_next (next_pt[j])
    );
  end

  jpd_merge u_merge (
    .clk      (clk),
    .ctrl     (merge_ctrl),
    .mags     (mags),
    .max_step (max_step),
    .steps    (steps),
    .clipped  (clipped)
  );

endmodule

// ===== hw/rtl/jpd_checker.sv =====
// Port-level checks for the joint path densifier, bound to the top level.
// Depends on jpd_pkg and joint_path_densifier_top.
module jpd_checker import jpd_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input angle_t          out_joint_0,
  input angle_t          out_joint_1,
  input angle_t          out_joint_2,
  input angle_t          out_joint_3,
  input angle_t          out_joint_4,
  input angle_t          out_joint_5,
  input angle_t          out_joint_6,
  input logic            last_of_run,
  input logic            steps_clipped
);

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_joint_0) &&
    $stable(out_joint_1) && $stable(out_joint_2) && $stable(out_joint_3) &&
    $stable(out_joint_4) && $stable(out_joint_5) && $stable(out_joint_6) &&
    $stable(last_of_run) && $stable(steps_clipped))
    else $error("stalled output beat changed");

  // Only one waypoint is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // While a run still has points to come, no new waypoint is taken.
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !in_ready)
    else $error("input ready in the middle of a run");

  // A waypoint never reaches the output in the cycle after its beat.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("output appeared too early");

endmodule

bind joint_path_densifier_top jpd_checker u_jpd_checker (.*);
